### hw/rtl/pov_column_scheduler_core_defines.svh
// Assertion macros shared by the column scheduler RTL.
`ifndef POV_COLUMN_SCHEDULER_CORE_DEFINES_SVH
`define POV_COLUMN_SCHEDULER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PCS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pcs: check failed");
// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PCS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcs: check failed");
`else
`define PCS_ASSERT_IMPL(label, ante, cons)
`define PCS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hw/rtl/pcs_pkg.sv
// Types and constants of the column scheduler.
package pcs_pkg;

	localparam logic [7:0] ODD_MASK  = 8'hAA;
	localparam logic [7:0] EVEN_MASK = 8'h55;
	localparam logic [6:0] SPP_MAX   = 7'd64;

	typedef enum logic [1:0] {
		CFG_STEPS_PER_PIXEL   = 2'd0,
		CFG_HIGHLIGHT_STEPS   = 2'd1,
		CFG_COLUMN_OFFSET     = 2'd2,
		CFG_REVERSE_DIRECTION = 2'd3
	} cfg_index_t;

	typedef enum logic {
		MODE_PUSH = 1'b0,
		MODE_TICK = 1'b1
	} mode_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] column_value;
	} in_word_t;

	typedef struct packed {
		logic       push_accepted;
		logic [7:0] led_pattern;
		logic [2:0] motor_phase;
		logic       motor_drive;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PUSH,
		ST_DIV1,
		ST_WAIT1,
		ST_DIV2,
		ST_WAIT2,
		ST_REDUCE,
		ST_RD_FRONT,
		ST_RD_BACK,
		ST_TICK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic clr_en;
		logic push;
		logic div_start;
		logic div_sel;
		logic latch_step;
		logic latch_back;
		logic reduce;
		logic rd_back;
		logic tick;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic in_mode;
		logic clr_last;
		logic div_done;
		logic bc_in_range;
		logic out_free;
	} status_t;

endpackage

### hw/rtl/pcs_div.sv
// Restoring divider, one quotient bit per cycle, 8-bit dividend by 7-bit divisor.
module pcs_div (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [7:0] dividend,
	input  logic [6:0] divisor,
	output logic       done,
	output logic [7:0] quot,
	output logic [6:0] rem
);
	logic       busy_q;
	logic       done_q;
	logic [2:0] cnt_q;
	logic [7:0] dvd_q;
	logic [7:0] rem_q;
	logic [7:0] trial;
	logic       fits;

	assign trial = {rem_q[6:0], dvd_q[7]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 3'd7);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// quotient bits shift in behind the dividend bits
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[6:0], fits};
			rem_q <= fits ? (trial - {1'b0, divisor}) : trial;
		end
	end

	assign done = done_q;
	assign quot = dvd_q;
	assign rem  = rem_q[6:0];
endmodule

### hw/rtl/pcs_ctrl.sv
// Sequencer of the column scheduler: one item at a time.
`include "pov_column_scheduler_core_defines.svh"
module pcs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  pcs_pkg::status_t status,
	output pcs_pkg::cmd_t    cmd
);
	import pcs_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (item_valid) state_d = (status.in_mode == MODE_TICK) ? ST_DIV1 : ST_PUSH;
			end
			ST_PUSH:     state_d = ST_FINISH;
			ST_DIV1:     state_d = ST_WAIT1;
			ST_WAIT1: begin
				if (status.div_done) state_d = ST_DIV2;
			end
			ST_DIV2:     state_d = ST_WAIT2;
			ST_WAIT2: begin
				if (status.div_done) state_d = ST_REDUCE;
			end
			ST_REDUCE: begin
				if (status.bc_in_range) state_d = ST_RD_FRONT;
			end
			ST_RD_FRONT: state_d = ST_RD_BACK;
			ST_RD_BACK:  state_d = ST_TICK;
			ST_TICK:     state_d = ST_FINISH;
			ST_FINISH: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default:     state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_CLEAR:    cmd.clr_en = 1'b1;
			ST_IDLE: begin
				item_ready  = 1'b1;
				cmd.capture = item_valid;
			end
			ST_PUSH:     cmd.push = 1'b1;
			ST_DIV1:     cmd.div_start = 1'b1;
			ST_WAIT1:    cmd.latch_step = status.div_done;
			ST_DIV2: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = 1'b1;
			end
			ST_WAIT2:    cmd.latch_back = status.div_done;
			ST_REDUCE:   cmd.reduce = !status.bc_in_range;
			ST_RD_FRONT: cmd.rd_back = 1'b0;
			ST_RD_BACK:  cmd.rd_back = 1'b1;
			ST_TICK:     cmd.tick = 1'b1;
			ST_FINISH:   cmd.load_out = status.out_free;
			default:     cmd = '0;
		endcase
	end

	`PCS_ASSERT_IMPL(a_load_needs_room, cmd.load_out, status.out_free)
	`PCS_ASSERT_NEXT(a_clear_holds, (state_q == ST_CLEAR) && !status.clr_last, state_q == ST_CLEAR)
	`PCS_ASSERT_IMPL(a_done_while_waiting, status.div_done, (state_q == ST_WAIT1) || (state_q == ST_WAIT2))
	`PCS_ASSERT_NEXT(a_reduce_exit, (state_q == ST_REDUCE) && status.bc_in_range, state_q == ST_RD_FRONT)
endmodule

### hw/rtl/pcs_datapath.sv
// Datapath: config registers, column ring buffer, step arithmetic, result register.
module pcs_datapath #(
	parameter int BUF_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [6:0]         cfg_data,
	input  pcs_pkg::in_word_t  item,
	input  logic               result_ready,
	output logic               result_valid,
	output pcs_pkg::out_word_t result,
	input  pcs_pkg::cmd_t      cmd,
	output pcs_pkg::status_t   status
);
	import pcs_pkg::*;

	localparam int AW = $clog2(BUF_DEPTH);
	localparam int CW = ((AW > 8) ? AW : 8) + 1;
	localparam logic [AW-1:0] PTR_LAST = AW'(BUF_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(BUF_DEPTH);

	// configuration
	logic [6:0] spp_q;
	logic [6:0] hl_cfg_q;
	logic [6:0] offset_q;
	logic       reverse_q;

	// control state
	logic [AW-1:0] rp_q;
	logic [AW-1:0] wp_q;
	logic [AW-1:0] clr_idx_q;
	logic [5:0]    pixel_step_q;
	logic [2:0]    phase_q;
	logic          stalled_q;
	logic          result_valid_q;

	// payload
	in_word_t  item_q;
	logic [5:0] step_q;
	logic [5:0] back_step_q;
	logic [7:0] bc_q;
	logic [7:0] front_q;
	logic [7:0] rd_q;
	out_word_t res_q;
	out_word_t out_q;

	logic [7:0] mem [BUF_DEPTH];

	logic [6:0] sps;
	logic [6:0] hl;
	logic [AW-1:0] rp_inc;
	logic [AW-1:0] rp_dec;
	logic [AW-1:0] wp_inc;
	logic          full;
	logic [CW-1:0] rp_ext;
	logic [CW-1:0] bc_ext;
	logic [CW-1:0] back_ext;
	logic [AW-1:0] back_idx;
	logic [AW-1:0] rd_addr;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic [7:0]    div_dividend;
	logic          div_done;
	logic [7:0]    div_quot;
	logic [6:0]    div_rem;
	logic [6:0]    back_raw;
	logic [6:0]    nstep_ext;
	logic [5:0]    nstep;
	logic [2:0]    nphase;
	logic          pop;
	logic          nstalled;
	logic [7:0]    leds;

	// effective steps per column, 1..64, and clamped highlight
	always_comb begin
		if (spp_q == 7'd0)        sps = 7'd1;
		else if (spp_q > SPP_MAX) sps = SPP_MAX;
		else                      sps = spp_q;
	end
	assign hl = (hl_cfg_q < sps) ? hl_cfg_q : sps;

	assign rp_inc = (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;
	assign rp_dec = (rp_q == '0) ? PTR_LAST : rp_q - 1'b1;
	assign wp_inc = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
	assign full   = (wp_q == rp_dec);

	// back column index, bc already reduced below the depth
	assign rp_ext   = CW'(rp_q);
	assign bc_ext   = CW'(bc_q);
	assign back_ext = (rp_ext >= bc_ext) ? (rp_ext - bc_ext) : (rp_ext + DEPTH_C - bc_ext);
	assign back_idx = back_ext[AW-1:0];
	assign rd_addr  = cmd.rd_back ? back_idx : rp_q;

	// first pass: pixel_step mod sps; second: (offset + sps - step) div/mod sps
	assign div_dividend = cmd.div_sel ? (8'(offset_q) + 8'(sps) - 8'(step_q))
	                                  : 8'(pixel_step_q);

	pcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (sps),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// back step is the negated remainder, modulo sps
	assign back_raw = (div_rem == 7'd0) ? 7'd0 : (sps - div_rem);

	assign nstep_ext = {1'b0, step_q} + 7'd1;
	assign nstep     = (nstep_ext == sps) ? 6'd0 : nstep_ext[5:0];
	assign nphase    = reverse_q ? (phase_q - 3'd1) : (phase_q + 3'd1);
	assign pop       = (nstep == 6'd0) && (rp_q != wp_q);
	assign nstalled  = stalled_q || ((nstep == 6'd0) && (rp_q == wp_q));

	always_comb begin
		leds = '0;
		if ({1'b0, step_q} <= hl)      leds = front_q & ODD_MASK;
		if ({1'b0, back_step_q} <= hl) leds = leds | (rd_q & EVEN_MASK);
	end

	assign mem_we    = cmd.clr_en || (cmd.push && !full);
	assign mem_waddr = cmd.clr_en ? clr_idx_q : wp_q;
	assign mem_wdata = cmd.clr_en ? 8'd0 : item_q.column_value;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spp_q          <= 7'd1;
			hl_cfg_q       <= '0;
			offset_q       <= '0;
			reverse_q      <= 1'b0;
			rp_q           <= '0;
			wp_q           <= '0;
			clr_idx_q      <= '0;
			pixel_step_q   <= '0;
			phase_q        <= '0;
			stalled_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					CFG_STEPS_PER_PIXEL:   spp_q     <= cfg_data;
					CFG_HIGHLIGHT_STEPS:   hl_cfg_q  <= cfg_data;
					CFG_COLUMN_OFFSET:     offset_q  <= cfg_data;
					CFG_REVERSE_DIRECTION: reverse_q <= cfg_data[0];
					default:               spp_q     <= spp_q;
				endcase
			end
			if (cmd.clr_en) clr_idx_q <= clr_idx_q + 1'b1;
			if (cmd.push && !full) begin
				wp_q      <= wp_inc;
				stalled_q <= 1'b0;
			end
			if (cmd.tick) begin
				pixel_step_q <= nstep;
				phase_q      <= nphase;
				stalled_q    <= nstalled;
				if (pop) rp_q <= rp_inc;
			end
			if (cmd.load_out)      result_valid_q <= 1'b1;
			else if (result_ready) result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= item;
		if (cmd.latch_step) step_q <= div_rem[5:0];
		if (cmd.latch_back) begin
			bc_q        <= div_quot;
			back_step_q <= back_raw[5:0];
		end else if (cmd.reduce) begin
			bc_q <= 8'(bc_ext - DEPTH_C);
		end
		if (cmd.rd_back) front_q <= rd_q;
		if (cmd.push) begin
			res_q.push_accepted <= !full;
			res_q.led_pattern   <= '0;
			res_q.motor_phase   <= phase_q;
			res_q.motor_drive   <= 1'b0;
		end else if (cmd.tick) begin
			res_q.push_accepted <= 1'b0;
			res_q.led_pattern   <= leds;
			res_q.motor_phase   <= nphase;
			res_q.motor_drive   <= !nstalled;
		end
		if (cmd.load_out) out_q <= res_q;
	end

	assign status.in_mode     = item.mode;
	assign status.clr_last    = (clr_idx_q == PTR_LAST);
	assign status.div_done    = div_done;
	assign status.bc_in_range = (bc_ext < DEPTH_C);
	assign status.out_free    = !result_valid_q || result_ready;

	assign result_valid = result_valid_q;
	assign result       = out_q;
endmodule

### hw/rtl/pov_column_scheduler_core.sv
// Top level of the persistence-of-vision column scheduler.
// Push word: captured in idle, then the push and finish states; the result register loads in finish.
// Tick word: two divider passes (each a start state and a wait for done), back index reduction
//   (one more reduce step per BUF_DEPTH in the back column count), two memory reads, update.
//   One word at a time; a held result holds off the next word.
// Reset: control state cleared, then a clearing pass zeroes the store; config writes taken.
module pov_column_scheduler_core #(
	parameter int BUF_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration, index as in cfg_index_t
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [6:0]         cfg_data,
	// input words
	input  logic               item_valid,
	output logic               item_ready,
	input  pcs_pkg::in_word_t  item,
	// result words
	output logic               result_valid,
	input  logic               result_ready,
	output pcs_pkg::out_word_t result
);
	import pcs_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencer: clearing pass, push, and the tick sequence
	// (two divides, back index reduction, front and back reads)
	pcs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	// ring buffer, pointers, stepper phase, result register
	pcs_datapath #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item         (item),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result       (result),
		.cmd          (cmd),
		.status       (status)
	);
endmodule

### tb/pcs_word_checker.sv
`timescale 1ns / 100ps
// Word checker for the column scheduler: mirrors registers, predicts results and compares.
module pcs_word_checker #(
	parameter int BUF_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [6:0]         cfg_data,
	input  logic               item_valid,
	input  logic               item_ready,
	input  pcs_pkg::in_word_t  item,
	input  logic               result_valid,
	input  logic               result_ready,
	input  pcs_pkg::out_word_t result,
	output int                 fault_count,
	output int                 words_pending
);
	import pcs_pkg::*;

	logic [7:0] col_mem [BUF_DEPTH];
	int         rd_ptr;
	int         wr_ptr;
	int         pix_step;
	logic [2:0] phase;
	bit         stall;
	logic [6:0] spp_reg;
	logic [6:0] hl_reg;
	logic [6:0] off_reg;
	logic       rev_reg;
	int         faults;
	out_word_t  awaited_results[$];

	function automatic out_word_t next_result_word(in_word_t w);
		out_word_t  r;
		int         eff;
		int         hl;
		int         off;
		int         step;
		int         back_step;
		int         back_cols;
		int         back_idx;
		logic [7:0] leds;
		r = '0;
		if (mode_t'(w.mode) == MODE_PUSH) begin
			// ring keeps one slot free
			if (wr_ptr != (rd_ptr + BUF_DEPTH - 1) % BUF_DEPTH) begin
				col_mem[wr_ptr] = w.column_value;
				wr_ptr = (wr_ptr + 1) % BUF_DEPTH;
				stall = 1'b0;
				r.push_accepted = 1'b1;
			end
			r.motor_phase = phase;
			return r;
		end
		eff = (spp_reg == '0) ? 1 : (spp_reg > SPP_MAX) ? int'(SPP_MAX) : int'(spp_reg);
		hl = (int'(hl_reg) < eff) ? int'(hl_reg) : eff;
		off = int'(off_reg);
		step = pix_step % eff;
		back_step = (step + eff - (off % eff)) % eff;
		back_cols = (off + eff - step) / eff;
		back_idx = (rd_ptr + BUF_DEPTH - (back_cols % BUF_DEPTH)) % BUF_DEPTH;
		leds = '0;
		if (step <= hl)
			leds = col_mem[rd_ptr] & ODD_MASK;
		if (back_step <= hl)
			leds = leds | (col_mem[back_idx] & EVEN_MASK);
		phase = rev_reg ? phase - 3'd1 : phase + 3'd1;
		step = (step + 1) % eff;
		pix_step = step;
		if (step == 0) begin
			if (rd_ptr != wr_ptr)
				rd_ptr = (rd_ptr + 1) % BUF_DEPTH;
			else
				stall = 1'b1;
		end
		r.led_pattern = leds;
		r.motor_phase = phase;
		r.motor_drive = !stall;
		return r;
	endfunction

	task automatic note_fault(string what, out_word_t want, out_word_t got);
		faults++;
		if (faults <= 10)
			$display("%0t: %s: want acc=%0b led=%02h ph=%0d drv=%0b, got acc=%0b led=%02h ph=%0d drv=%0b",
				$realtime, what, want.push_accepted, want.led_pattern, want.motor_phase,
				want.motor_drive, got.push_accepted, got.led_pattern, got.motor_phase,
				got.motor_drive);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			for (int i = 0; i < BUF_DEPTH; i++)
				col_mem[i] = '0;
			rd_ptr = 0;
			wr_ptr = 0;
			pix_step = 0;
			phase = '0;
			stall = 1'b0;
			spp_reg = 7'd1;
			hl_reg = '0;
			off_reg = '0;
			rev_reg = 1'b0;
			faults = 0;
			awaited_results.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					CFG_STEPS_PER_PIXEL:   spp_reg = cfg_data;
					CFG_HIGHLIGHT_STEPS:   hl_reg = cfg_data;
					CFG_COLUMN_OFFSET:     off_reg = cfg_data;
					CFG_REVERSE_DIRECTION: rev_reg = cfg_data[0];
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				if (awaited_results.size() == 0) begin
					note_fault("unexpected result word", '0, result);
				end else begin
					want = awaited_results.pop_front();
					if (want.push_accepted !== result.push_accepted ||
						want.led_pattern !== result.led_pattern ||
						want.motor_phase !== result.motor_phase ||
						want.motor_drive !== result.motor_drive)
						note_fault("result word mismatch", want, result);
				end
			end
			if (item_valid && item_ready)
				awaited_results.push_back(next_result_word(item));
		end
		fault_count <= faults;
		words_pending <= awaited_results.size();
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the column scheduler: clock, reset, stimulus and verdict.
module tb_top;
	import pcs_pkg::*;

	localparam int BUF_DEPTH     = 256;
	localparam int ITEM_TARGET   = 1100;
	// extra idle time after the last result, enough for the block to return to idle
	localparam int SETTLE_CYCLES = 40;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	logic [1:0] cfg_index;
	logic [6:0] cfg_data;
	logic      item_valid;
	logic      item_ready;
	in_word_t  item;
	logic      result_valid;
	logic      result_ready;
	out_word_t result;
	int        fault_count;
	int        words_pending;
	int        words_sent;
	bit        quiet;

	pov_column_scheduler_core #(
		.BUF_DEPTH(BUF_DEPTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	pcs_word_checker #(
		.BUF_DEPTH(BUF_DEPTH)
	) word_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.fault_count  (fault_count),
		.words_pending(words_pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop
	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// receiver back-pressure: drops ready about one cycle in ten, never while quiet
	always @(posedge clk) begin
		result_ready <= quiet || ($urandom_range(99) >= 10);
	end

	// offer one word; valid stays up from the previous word unless a gap is taken
	task automatic send_word(mode_t m, logic [7:0] v);
		int       gap;
		in_word_t w;
		gap = 0;
		if (!quiet && $urandom_range(99) < 10)
			gap = $urandom_range(1, 4);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		w.mode = m;
		w.column_value = v;
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (!item_ready);
		words_sent++;
	endtask

	// hold the sender until every awaited result is back, then let the block go idle
	task automatic settle();
		item_valid <= 1'b0;
		do @(posedge clk); while (words_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// only called with the block idle
	task automatic write_regs(logic [6:0] spp, logic [6:0] hl, logic [6:0] off, logic rev);
		cfg_we <= 1'b1;
		cfg_index <= CFG_STEPS_PER_PIXEL;
		cfg_data <= spp;
		@(posedge clk);
		cfg_index <= CFG_HIGHLIGHT_STEPS;
		cfg_data <= hl;
		@(posedge clk);
		cfg_index <= CFG_COLUMN_OFFSET;
		cfg_data <= off;
		@(posedge clk);
		cfg_index <= CFG_REVERSE_DIRECTION;
		cfg_data <= {6'd0, rev};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int         p;
		int         base;
		int         eff;
		int         k;
		int         t;
		int         budget;
		int         off_top;
		logic [6:0] spp;
		logic [6:0] hl;
		logic [6:0] off;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_STEPS_PER_PIXEL;
		cfg_data <= '0;
		item_valid <= 1'b0;
		item <= '0;
		quiet <= 1'b0;
		words_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed part ---
		// tick on an empty buffer stalls the motor drive
		send_word(MODE_TICK, 8'h00);
		// pushes clear the stall; extreme column patterns
		send_word(MODE_PUSH, 8'hFF);
		send_word(MODE_PUSH, 8'h00);
		send_word(MODE_PUSH, 8'hA5);
		send_word(MODE_PUSH, 8'h5A);
		repeat (4) send_word(MODE_TICK, 8'hFF);
		settle();
		// zero steps per pixel used as one, highlight clamped, large offset, reverse
		write_regs(7'd0, 7'd127, 7'd127, 1'b1);
		send_word(MODE_PUSH, 8'h81);
		repeat (3) send_word(MODE_TICK, 8'h3C);
		settle();
		// steps per pixel beyond the top saturates
		write_regs(7'd127, 7'd64, 7'd0, 1'b0);
		send_word(MODE_PUSH, 8'hFF);
		repeat (5) send_word(MODE_TICK, 8'h00);
		settle();
		// pixel step left beyond a reduced steps per pixel wraps
		write_regs(7'd3, 7'd1, 7'd5, 1'b0);
		repeat (3) send_word(MODE_TICK, 8'hC3);

		// --- random part: one register setting per phase ---
		base = words_sent;
		p = 0;
		while (words_sent - base < ITEM_TARGET) begin
			settle();
			// one phase with no random send gaps and no ready drops
			quiet <= (p == 3);
			if (p == 1) begin
				// fill to the brim and beyond, then drain most of it
				write_regs(7'd1, 7'($urandom_range(127)), 7'($urandom_range(127)),
					1'($urandom_range(1)));
				repeat (258) send_word(MODE_PUSH, 8'($urandom));
				repeat (200) send_word(MODE_TICK, 8'($urandom));
			end else begin
				case ($urandom_range(9))
					0:       spp = 7'd0;
					1:       spp = 7'd127;
					2:       spp = SPP_MAX;
					default: spp = 7'($urandom_range(1, 6));
				endcase
				eff = (spp == '0) ? 1 : (spp > SPP_MAX) ? int'(SPP_MAX) : int'(spp);
				case ($urandom_range(3))
					0:       hl = 7'd0;
					1:       hl = 7'd127;
					default: hl = 7'($urandom_range(0, eff + 1));
				endcase
				off_top = (3 * eff - 1 > 127) ? 127 : 3 * eff - 1;
				case ($urandom_range(3))
					0:       off = 7'd127;
					1:       off = 7'd0;
					default: off = 7'($urandom_range(0, off_top));
				endcase
				write_regs(spp, hl, off, 1'($urandom_range(1)));
				budget = words_sent + $urandom_range(30, 80);
				while (words_sent < budget) begin
					if ($urandom_range(9) == 0) begin
						// noise word, either kind
						send_word(mode_t'($urandom_range(1)), 8'($urandom));
					end else begin
						// a few columns, then up to enough ticks to show them and sometimes run dry
						k = $urandom_range(1, 6);
						repeat (k) send_word(MODE_PUSH, 8'($urandom));
						t = $urandom_range(1, k * eff + 2);
						if (t > 40)
							t = 40;
						repeat (t) send_word(MODE_TICK, 8'($urandom));
					end
					// sender sometimes holds off until everything is back
					if ($urandom_range(19) == 0)
						settle();
				end
			end
			p++;
		end

		settle();
		if (fault_count == 0 && words_pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
